### hdl/owtb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owtb_pkg
// Types, widths and constants shared by the odometry and target bearing block.
// ----------------------------------------------------------------------------
package owtb_pkg;

   localparam int POS_W   = 24;
   localparam int HEAD_W  = 22;
   localparam int BEAR_W  = 15;
   localparam int DIST_W  = 25;
   localparam int DELTA_W = 25;
   localparam int REQ_W   = 144;
   localparam int RSP_W   = 112;

   // cordic datapath widths
   localparam int CW     = 57;
   localparam int ZW     = 34;
   localparam int MA_W   = 32;
   localparam int MB_W   = 25;
   localparam int MP_W   = 57;
   localparam int STEP_W = 5;

   localparam int DIV_STEPS  = 23;
   localparam int SQRT_STEPS = 25;
   localparam int MAX_STEPS  = 24;
   localparam int VEC_SHIFT  = 30;
   localparam int SQ_W       = 50;
   localparam int ROOT_W     = 25;
   localparam int SREM_W     = 27;
   localparam int NUM_W      = 46;

   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_SET    = 1'b1;

   // 92 turns of 1/128 degree, keeps the heading sum positive
   localparam logic signed [24:0] TURN_BIAS = 25'sd4239360;
   localparam logic [5:0] DIV_BY = 6'd45;
   localparam logic signed [CW-1:0] GAIN_Q30 = 57'sd652032874;
   localparam logic signed [ZW-1:0] QUARTER_BA = 34'sd1073741824;
   localparam logic signed [ZW-1:0] HALF_BA = 34'sd2147483648;
   localparam logic signed [MB_W-1:0] DEG64_SCALE = 25'sd23040;
   localparam logic signed [15:0] QUARTER_64 = 16'sd5760;
   localparam logic signed [15:0] HALF_64 = 16'sd11520;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DIV, ST_RINIT, ST_ROT, ST_SC, ST_MULX, ST_MULY, ST_POS,
      ST_DXY, ST_VINIT, ST_VEC, ST_ATAN, ST_SQX, ST_SQY, ST_SQINIT, ST_SQRT,
      ST_DONE
   } owtb_state_type;

   typedef enum logic [2:0] {
      MUL_S, MUL_C, MUL_ATAN, MUL_SQX, MUL_SQY
   } owtb_mul_type;

   typedef struct packed {
      logic              load;
      logic              div_step;
      logic              rot_init;
      logic              vec_init;
      logic              cordic_step;
      logic              vec_mode;
      logic              sc_take;
      logic              mul_en;
      owtb_mul_type      mul_sel;
      logic              theta_take;
      logic              pos_take;
      logic              dxy_take;
      logic              sq_init;
      logic              sqrt_step;
      logic              finish;
      logic [STEP_W-1:0] step;
   } owtb_cmd_type;

   typedef struct packed {
      logic out_busy;
   } owtb_status_type;

   // atan(2^-i) with 2^32 per turn
   function automatic logic [31:0] atan_entry(input logic [STEP_W-1:0] i);
      logic [31:0] v;
      case (i)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2F9;
         5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;
         5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;
         5'd23: v = 32'h00000051;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

### hdl/owtb_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owtb_cordic
// Shared iterative cordic, one micro-rotation per cycle, rotation or vectoring.
// ----------------------------------------------------------------------------
module owtb_cordic (
   input  wire logic                           clock,
   input  wire logic                           init,
   input  wire logic                           step,
   input  wire logic                           vec_mode,
   input  wire logic [owtb_pkg::STEP_W-1:0]    shift,
   input  wire logic signed [owtb_pkg::CW-1:0] init_x,
   input  wire logic signed [owtb_pkg::CW-1:0] init_y,
   input  wire logic signed [owtb_pkg::ZW-1:0] init_z,
   output logic signed [owtb_pkg::CW-1:0]      x,
   output logic signed [owtb_pkg::ZW-1:0]      z,
   output logic signed [owtb_pkg::CW-1:0]      y
);
   import owtb_pkg::*;

   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [ZW-1:0] z_ff, z_in, at;
   logic                 plus;

   always_comb begin
      xs = x_ff >>> shift;
      ys = y_ff >>> shift;
      at = ZW'(atan_entry(shift));
      // rotation drives z to zero, vectoring drives y to zero
      plus = vec_mode ? y_ff[CW-1] : !z_ff[ZW-1];
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      if (init) begin
         x_in = init_x;
         y_in = init_y;
         z_in = init_z;
      end else if (step) begin
         if (plus) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign x = x_ff;
   assign y = y_ff;
   assign z = z_ff;

endmodule
`default_nettype wire

### hdl/owtb_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owtb_dp
// Datapath: odometry state, angle divider, shared multiplier, cordic, square
// root and the result register.
// ----------------------------------------------------------------------------
module owtb_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [owtb_pkg::REQ_W-1:0]    req_tdata,
   input  wire logic                          req_mode,
   input  wire owtb_pkg::owtb_cmd_type        cmd,
   output owtb_pkg::owtb_status_type          status,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [owtb_pkg::RSP_W-1:0]         rsp_tdata
);
   import owtb_pkg::*;

   logic signed [POS_W-1:0]  f_travel, f_set_x, f_set_y, f_tx, f_ty;
   logic signed [HEAD_W-1:0] f_heading;
   logic                     f_backward;

   logic signed [POS_W-1:0]  x_pos_ff, x_pos_in, y_pos_ff, y_pos_in;
   logic signed [POS_W-1:0]  last_travel_ff, last_travel_in;
   logic signed [HEAD_W-1:0] last_angle_ff, last_angle_in;
   logic signed [HEAD_W-1:0] latest_angle_ff, latest_angle_in;
   logic                     primed_ff, primed_in;

   logic signed [POS_W-1:0]   tx_ff, tx_in, ty_ff, ty_in;
   logic                      bw_ff, bw_in;
   logic signed [DELTA_W-1:0] delta_ff, delta_in;
   logic [NUM_W-1:0]          num_ff, num_in;
   logic [5:0]                drem_ff, drem_in;
   logic [31:0]               q_ff, q_in;
   logic                      neg_ff, neg_in;
   logic signed [MA_W-1:0]    s_ff, s_in, c_ff, c_in;
   logic signed [MP_W-1:0]    px_ff, px_in, py_ff, py_in;
   logic signed [24:0]        dx_ff, dx_in, dy_ff, dy_in;
   logic signed [24:0]        theta0_ff, theta0_in;
   logic [SQ_W-1:0]           sqv_ff, sqv_in;
   logic [ROOT_W-1:0]         root_ff, root_in;
   logic [SREM_W-1:0]         srem_ff, srem_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]          rsp_data_ff, rsp_data_in;

   logic signed [POS_W-1:0]  lt_eff;
   logic signed [HEAD_W-1:0] la_eff;
   logic signed [24:0]       asum;
   logic [7:0]               dt;
   logic [1:0]               qd;
   logic [7:0]               dr;
   logic signed [ZW-1:0]     zb, zfold;
   logic                     zneg;
   logic signed [CW-1:0]     ix, iy, cx, cy;
   logic signed [ZW-1:0]     iz, cz;
   logic signed [24:0]       absdy;
   logic signed [MA_W-1:0]   mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic signed [MP_W-1:0]   prod, rx, ry, ra;
   logic signed [27:0]       sumx, sumy;
   logic [28:0]              st, strial;
   logic signed [15:0]       th;
   logic [DIST_W-1:0]        dist_rnd;

   assign f_travel   = $signed(req_tdata[23:0]);
   assign f_heading  = $signed(req_tdata[45:24]);
   assign f_set_x    = $signed(req_tdata[69:46]);
   assign f_set_y    = $signed(req_tdata[93:70]);
   assign f_tx       = $signed(req_tdata[117:94]);
   assign f_ty       = $signed(req_tdata[141:118]);
   assign f_backward = req_tdata[142];

   // shared multiplier
   always_comb begin
      case (cmd.mul_sel)
         MUL_S: begin
            mul_a = s_ff;
            mul_b = delta_ff;
         end
         MUL_C: begin
            mul_a = c_ff;
            mul_b = delta_ff;
         end
         MUL_ATAN: begin
            mul_a = cz[MA_W-1:0];
            mul_b = DEG64_SCALE;
         end
         MUL_SQX: begin
            mul_a = MA_W'(dx_ff);
            mul_b = dx_ff;
         end
         MUL_SQY: begin
            mul_a = MA_W'(dy_ff);
            mul_b = dy_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign prod = mul_a * mul_b;

   // cordic start vectors
   always_comb begin
      zb = ZW'($signed(q_ff));
      zfold = zb;
      zneg = 1'b0;
      if (zb > QUARTER_BA) begin
         zfold = zb - HALF_BA;
         zneg = 1'b1;
      end else if (zb < -QUARTER_BA) begin
         zfold = zb + HALF_BA;
         zneg = 1'b1;
      end
      absdy = dy_ff[24] ? -dy_ff : dy_ff;
      if (cmd.rot_init) begin
         ix = GAIN_Q30;
         iy = '0;
         iz = zfold;
      end else begin
         ix = CW'(absdy) <<< VEC_SHIFT;
         iy = CW'(dx_ff) <<< VEC_SHIFT;
         iz = '0;
      end
   end

   owtb_cordic u_cordic (
      .clock    (clock),
      .init     (cmd.rot_init | cmd.vec_init),
      .step     (cmd.cordic_step),
      .vec_mode (cmd.vec_mode),
      .shift    (cmd.step),
      .init_x   (ix),
      .init_y   (iy),
      .init_z   (iz),
      .x        (cx),
      .z        (cz),
      .y        (cy)
   );

   always_comb begin
      x_pos_in        = x_pos_ff;
      y_pos_in        = y_pos_ff;
      last_travel_in  = last_travel_ff;
      last_angle_in   = last_angle_ff;
      latest_angle_in = latest_angle_ff;
      primed_in       = primed_ff;
      tx_in     = tx_ff;
      ty_in     = ty_ff;
      bw_in     = bw_ff;
      delta_in  = delta_ff;
      num_in    = num_ff;
      drem_in   = drem_ff;
      q_in      = q_ff;
      neg_in    = neg_ff;
      s_in      = s_ff;
      c_in      = c_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      theta0_in = theta0_ff;
      sqv_in    = sqv_ff;
      root_in   = root_ff;
      srem_in   = srem_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;

      lt_eff = primed_ff ? last_travel_ff : f_travel;
      la_eff = primed_ff ? last_angle_ff : f_heading;
      asum = 25'(f_heading) + 25'(la_eff) + TURN_BIAS;

      if (cmd.load) begin
         tx_in = f_tx;
         ty_in = f_ty;
         bw_in = f_backward;
         if (req_mode == MODE_SAMPLE) begin
            delta_in = 25'(f_travel) - 25'(lt_eff);
            // heading sum * 2^22 / 45 gives the binary angle, full turns fall off the top
            num_in = {asum[23:0], 22'd22};
            drem_in = '0;
            last_travel_in = f_travel;
            last_angle_in = f_heading;
            latest_angle_in = f_heading;
            primed_in = 1'b1;
         end else begin
            x_pos_in = f_set_x;
            y_pos_in = f_set_y;
            primed_in = 1'b0;
         end
      end

      // radix-4 restoring division by 45
      dt = {drem_ff, num_ff[NUM_W-1 -: 2]};
      if (dt >= 8'd135) begin
         qd = 2'd3;
         dr = dt - 8'd135;
      end else if (dt >= 8'd90) begin
         qd = 2'd2;
         dr = dt - 8'd90;
      end else if (dt >= 8'(DIV_BY)) begin
         qd = 2'd1;
         dr = dt - 8'(DIV_BY);
      end else begin
         qd = 2'd0;
         dr = dt;
      end
      if (cmd.div_step) begin
         drem_in = dr[5:0];
         q_in = {q_ff[29:0], qd};
         num_in = num_ff << 2;
      end

      if (cmd.rot_init) begin
         neg_in = zneg;
      end
      if (cmd.sc_take) begin
         s_in = neg_ff ? MA_W'(-cy) : MA_W'(cy);
         c_in = neg_ff ? MA_W'(-cx) : MA_W'(cx);
      end

      if (cmd.mul_en) begin
         if (cmd.mul_sel == MUL_C || cmd.mul_sel == MUL_SQY) begin
            py_in = prod;
         end else begin
            px_in = prod;
         end
      end

      rx = px_ff + 57'sd536870912;
      ry = py_ff + 57'sd536870912;
      sumx = 28'(x_pos_ff) + 28'(rx >>> 30);
      sumy = 28'(y_pos_ff) + 28'(ry >>> 30);
      if (cmd.pos_take) begin
         x_pos_in = (sumx > 28'sd8388607) ? 24'sh7FFFFF :
                    (sumx < -28'sd8388608) ? 24'sh800000 : sumx[23:0];
         y_pos_in = (sumy > 28'sd8388607) ? 24'sh7FFFFF :
                    (sumy < -28'sd8388608) ? 24'sh800000 : sumy[23:0];
      end

      if (cmd.dxy_take) begin
         dx_in = 25'(tx_ff) - 25'(x_pos_ff);
         dy_in = 25'(ty_ff) - 25'(y_pos_ff);
      end

      ra = px_ff + 57'sd2147483648;
      if (cmd.theta_take) begin
         theta0_in = 25'(ra >>> 32);
      end

      // digit-by-digit square root, one result bit a cycle
      st = {srem_ff, sqv_ff[SQ_W-1 -: 2]};
      strial = {2'b00, root_ff, 2'b01};
      if (cmd.sq_init) begin
         sqv_in = px_ff[SQ_W-1:0] + py_ff[SQ_W-1:0];
         root_in = '0;
         srem_in = '0;
      end else if (cmd.sqrt_step) begin
         sqv_in = sqv_ff << 2;
         if (st >= strial) begin
            srem_in = SREM_W'(st - strial);
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            srem_in = SREM_W'(st);
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
      end

      // bearing fix-ups for a level target and for facing away
      if (dy_ff == 25'sd0) begin
         th = (dx_ff > 25'sd0) ? QUARTER_64 : (dx_ff < 25'sd0) ? -QUARTER_64 : 16'sd0;
      end else begin
         th = dy_ff[24] ? -16'(theta0_ff) : 16'(theta0_ff);
         if ((!bw_ff && dy_ff < 25'sd0) || (bw_ff && dy_ff > 25'sd0)) begin
            if ((dx_ff > 25'sd0 && dy_ff > 25'sd0) || (dx_ff < 25'sd0 && dy_ff < 25'sd0)) begin
               th = th - HALF_64;
            end else begin
               th = th + HALF_64;
            end
         end
      end
      dist_rnd = root_ff + DIST_W'(srem_ff > SREM_W'(root_ff));

      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = {2'b00, dist_rnd, th[BEAR_W-1:0], latest_angle_ff, y_pos_ff, x_pos_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_pos_ff        <= '0;
         y_pos_ff        <= '0;
         last_travel_ff  <= '0;
         last_angle_ff   <= '0;
         latest_angle_ff <= '0;
         primed_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         x_pos_ff        <= x_pos_in;
         y_pos_ff        <= y_pos_in;
         last_travel_ff  <= last_travel_in;
         last_angle_ff   <= last_angle_in;
         latest_angle_ff <= latest_angle_in;
         primed_ff       <= primed_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tx_ff       <= tx_in;
      ty_ff       <= ty_in;
      bw_ff       <= bw_in;
      delta_ff    <= delta_in;
      num_ff      <= num_in;
      drem_ff     <= drem_in;
      q_ff        <= q_in;
      neg_ff      <= neg_in;
      s_ff        <= s_in;
      c_ff        <= c_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      theta0_ff   <= theta0_in;
      sqv_ff      <= sqv_in;
      root_ff     <= root_in;
      srem_ff     <= srem_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.out_busy = rsp_valid_ff & ~rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

### hdl/owtb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owtb_ctrl
// Sequencer: walks one item through division, cordic, multiply and root steps.
// ----------------------------------------------------------------------------
module owtb_ctrl #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   input  wire logic                      req_mode,
   output logic                           req_tready,
   input  wire owtb_pkg::owtb_status_type status,
   output owtb_pkg::owtb_cmd_type         cmd
);
   import owtb_pkg::*;

   localparam int StepsEff = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
   localparam logic [STEP_W-1:0] CORDIC_LAST = STEP_W'(StepsEff - 1);
   localparam logic [STEP_W-1:0] DIV_LAST    = STEP_W'(DIV_STEPS - 1);
   localparam logic [STEP_W-1:0] SQRT_LAST   = STEP_W'(SQRT_STEPS - 1);

   owtb_state_type    state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (req_mode == MODE_SET) ? ST_DXY : ST_DIV;
            end
         end
         ST_DIV:    if (cnt_ff == DIV_LAST) state_in = ST_RINIT;
         ST_RINIT:  state_in = ST_ROT;
         ST_ROT:    if (cnt_ff == CORDIC_LAST) state_in = ST_SC;
         ST_SC:     state_in = ST_MULX;
         ST_MULX:   state_in = ST_MULY;
         ST_MULY:   state_in = ST_POS;
         ST_POS:    state_in = ST_DXY;
         ST_DXY:    state_in = ST_VINIT;
         ST_VINIT:  state_in = ST_VEC;
         ST_VEC:    if (cnt_ff == CORDIC_LAST) state_in = ST_ATAN;
         ST_ATAN:   state_in = ST_SQX;
         ST_SQX:    state_in = ST_SQY;
         ST_SQY:    state_in = ST_SQINIT;
         ST_SQINIT: state_in = ST_SQRT;
         ST_SQRT:   if (cnt_ff == SQRT_LAST) state_in = ST_DONE;
         ST_DONE:   if (!status.out_busy) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
      cnt_in = (state_in != state_ff) ? '0 : cnt_ff + 1'b1;
   end

   always_comb begin
      cmd = '0;
      cmd.mul_sel = MUL_S;
      cmd.step = cnt_ff;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load = req_tvalid;
         end
         ST_DIV:   cmd.div_step = 1'b1;
         ST_RINIT: cmd.rot_init = 1'b1;
         ST_ROT:   cmd.cordic_step = 1'b1;
         ST_SC:    cmd.sc_take = 1'b1;
         ST_MULX: begin
            cmd.mul_en = 1'b1;
            cmd.mul_sel = MUL_S;
         end
         ST_MULY: begin
            cmd.mul_en = 1'b1;
            cmd.mul_sel = MUL_C;
         end
         ST_POS:   cmd.pos_take = 1'b1;
         ST_DXY:   cmd.dxy_take = 1'b1;
         ST_VINIT: cmd.vec_init = 1'b1;
         ST_VEC: begin
            cmd.cordic_step = 1'b1;
            cmd.vec_mode = 1'b1;
         end
         ST_ATAN: begin
            cmd.mul_en = 1'b1;
            cmd.mul_sel = MUL_ATAN;
         end
         ST_SQX: begin
            cmd.mul_en = 1'b1;
            cmd.mul_sel = MUL_SQX;
            cmd.theta_take = 1'b1;
         end
         ST_SQY: begin
            cmd.mul_en = 1'b1;
            cmd.mul_sel = MUL_SQY;
         end
         ST_SQINIT: cmd.sq_init = 1'b1;
         ST_SQRT:   cmd.sqrt_step = 1'b1;
         ST_DONE:   cmd.finish = !status.out_busy;
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
`default_nettype wire

### hdl/odometry_with_target_bearing.sv
`default_nettype none
// ----------------------------------------------------------------------------
// odometry_with_target_bearing
// Midpoint heading dead reckoning with bearing and distance to a target.
// ----------------------------------------------------------------------------
//  channel  direction  transfer when           contents
//  req      in         req_tvalid & req_tready  one sample or set-position item
//  rsp      out        rsp_tvalid & rsp_tready  position, heading, bearing, distance
//
// a sample item passes the 23-step angle divider, the shared cordic (rotation,
// then vectoring) and the 25-step square root; a set item skips the divider and
// the rotation. the cordic runs N steps, N at most 24. one item is in flight at a time.
// reset clears position, captured references, the output heading and the result valid flag.
// a finished result waits in the output register while the next item is taken.
module odometry_with_target_bearing #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   // travel, heading, set_x, set_y, target_x, target_y, backward, zero pad
   input  wire logic [owtb_pkg::REQ_W-1:0] req_tdata,
   // mode
   input  wire logic [0:0]                 req_tuser,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   // pos_x, pos_y, heading_out, bearing, distance, zero pad
   output logic [owtb_pkg::RSP_W-1:0]      rsp_tdata
);
   import owtb_pkg::*;

   owtb_cmd_type    cmd;
   owtb_status_type status;

   owtb_ctrl #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_mode   (req_tuser[0]),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   owtb_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_mode   (req_tuser[0]),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

### sim/odometry_with_target_bearing_tb.sv
// ----------------------------------------------------------------------------
// odometry_with_target_bearing_tb
// Drives sample and set-position transfers with random gaps on both channels.
// Each accepted request updates a local dead-reckoning model. That model
// predicts position, heading, bearing and distance for every response.
// ----------------------------------------------------------------------------
module odometry_with_target_bearing_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import owtb_pkg::*;

   localparam int STEPS_CFG = 16;
   localparam int NSTEP = (STEPS_CFG > 24) ? 24 : STEPS_CFG;
   localparam longint P_MAX = 8388607;
   localparam longint P_MIN = -8388608;

   localparam longint ATAN_BA [24] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
   };

   typedef struct {
      logic               mode;
      logic signed [23:0] travel;
      logic signed [21:0] heading;
      logic signed [23:0] set_x;
      logic signed [23:0] set_y;
      logic signed [23:0] target_x;
      logic signed [23:0] target_y;
      logic               backward;
   } odo_req_type;

   typedef struct packed {
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic signed [21:0] heading_out;
      logic signed [14:0] bearing;
      logic [24:0]        distance;
   } odo_rsp_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata = '0;
   logic [0:0]        req_tuser = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;

   odometry_with_target_bearing #(.CORDIC_STEPS(STEPS_CFG)) u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // dead-reckoning state of the model
   longint      odo_x, odo_y, ref_travel, ref_heading, cur_heading;
   bit          primed;
   odo_rsp_type pending_rsp [$];
   int          errors = 0;
   bit          idle_on = 1'b1;

   function automatic void heading_trig(input longint a, output longint s,
                                        output longint c);
      longint r, z, x, y, t;
      longint unsigned ba;
      bit neg;
      neg = 1'b0;
      r = a % 46080;
      if (r < 0) r += 46080;
      ba = ((longint'(r) << 32) + 23040) / 46080;
      z = (ba >= 64'h80000000) ? longint'(ba) - 64'sh100000000 : longint'(ba);
      if (z > 64'sd1073741824) begin
         z -= 64'sd2147483648; neg = 1'b1;
      end else if (z < -64'sd1073741824) begin
         z += 64'sd2147483648; neg = 1'b1;
      end
      x = 652032874;
      y = 0;
      for (int i = 0; i < NSTEP; i++) begin
         if (z >= 0) begin
            t = x - (y >>> i); y = y + (x >>> i); x = t; z -= ATAN_BA[i];
         end else begin
            t = x + (y >>> i); y = y - (x >>> i); x = t; z += ATAN_BA[i];
         end
      end
      c = neg ? -x : x;
      s = neg ? -y : y;
   endfunction

   function automatic longint target_angle(input longint xv, input longint yv);
      longint x, y, z, t;
      x = xv * 64'sd1073741824;
      y = yv * 64'sd1073741824;
      z = 0;
      for (int i = 0; i < NSTEP; i++) begin
         if (y >= 0) begin
            t = x + (y >>> i); y = y - (x >>> i); x = t; z += ATAN_BA[i];
         end else begin
            t = x - (y >>> i); y = y + (x >>> i); x = t; z -= ATAN_BA[i];
         end
      end
      return (z * 23040 + 64'sd2147483648) >>> 32;
   endfunction

   function automatic longint unsigned range_root(input longint unsigned v);
      longint unsigned r, b, n;
      r = 0;
      b = 64'd1 << 62;
      n = v;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b; r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      if (v - r * r > r) r++;
      return r;
   endfunction

   function automatic longint clamp24(input longint v);
      if (v > P_MAX) return P_MAX;
      if (v < P_MIN) return P_MIN;
      return v;
   endfunction

   function automatic odo_rsp_type odometry_update(input odo_req_type it);
      odo_rsp_type o;
      longint dx, dy, theta, s, c, delta, tr, hd;
      if (it.mode == MODE_SAMPLE) begin
         tr = it.travel;
         hd = it.heading;
         if (!primed) begin
            ref_travel = tr; ref_heading = hd; primed = 1'b1;
         end
         delta = tr - ref_travel;
         heading_trig(hd + ref_heading, s, c);
         odo_x = clamp24(odo_x + ((delta * s + 536870912) >>> 30));
         odo_y = clamp24(odo_y + ((delta * c + 536870912) >>> 30));
         cur_heading = hd;
         ref_travel = tr;
         ref_heading = hd;
      end else begin
         odo_x = it.set_x;
         odo_y = it.set_y;
         primed = 1'b0;
      end
      dx = longint'(it.target_x) - odo_x;
      dy = longint'(it.target_y) - odo_y;
      if (dy == 0) begin
         theta = dx > 0 ? 5760 : (dx < 0 ? -5760 : 0);
      end else begin
         theta = target_angle(dy > 0 ? dy : -dy, dx);
         if (dy < 0) theta = -theta;
         if ((!it.backward && dy < 0) || (it.backward && dy > 0)) begin
            if ((dx > 0 && dy > 0) || (dx < 0 && dy < 0)) theta -= 11520;
            else theta += 11520;
         end
      end
      o.pos_x = odo_x[23:0];
      o.pos_y = odo_y[23:0];
      o.heading_out = cur_heading[21:0];
      o.bearing = theta[14:0];
      o.distance = range_root(longint'(dx * dx) + longint'(dy * dy));
      return o;
   endfunction

   function automatic odo_req_type mk(input logic m, input longint tr, input longint hd,
                                      input longint sx, input longint sy,
                                      input longint tx, input longint ty,
                                      input logic bw);
      odo_req_type r;
      r.mode = m; r.travel = tr[23:0]; r.heading = hd[21:0];
      r.set_x = sx[23:0]; r.set_y = sy[23:0];
      r.target_x = tx[23:0]; r.target_y = ty[23:0]; r.backward = bw;
      return r;
   endfunction

   function automatic odo_req_type noise_item();
      return mk($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom_range(0, 1));
   endfunction

   task automatic send_item(input odo_req_type it);
      req_tdata <= {1'b0, it.backward, it.target_y, it.target_x, it.set_y,
                    it.set_x, it.heading, it.travel};
      req_tuser <= it.mode;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_rsp.push_back(odometry_update(it));
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   // response sink with random stall bursts
   initial begin
      forever begin
         @(posedge clock);
         if (idle_on && !reset && $urandom_range(0, 11) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      odo_rsp_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.pos_x = rsp_tdata[23:0];
         got.pos_y = rsp_tdata[47:24];
         got.heading_out = rsp_tdata[69:48];
         got.bearing = rsp_tdata[84:70];
         got.distance = rsp_tdata[109:85];
         if (pending_rsp.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response transfer %h", rsp_tdata);
         end else begin
            want = pending_rsp.pop_front();
            if (got != want) begin
               errors++;
               if (errors <= 10)
                  $display({"mismatch exp x=%0d y=%0d h=%0d b=%0d d=%0d",
                            " got x=%0d y=%0d h=%0d b=%0d d=%0d"},
                           want.pos_x, want.pos_y, want.heading_out, want.bearing,
                           want.distance, got.pos_x, got.pos_y, got.heading_out,
                           got.bearing, got.distance);
            end
         end
      end
   end

   task automatic test_first_capture();
      send_item(mk(MODE_SAMPLE, 5000, 1234, 0, 0, 100, 200, 1'b0));
      send_item(mk(MODE_SAMPLE, 7560, 1500, 0, 0, 100, 200, 1'b0));
      send_item(mk(MODE_SAMPLE, 9000, -3000, 0, 0, -40, 900, 1'b1));
   endtask

   task automatic test_set_position();
      send_item(mk(MODE_SET, -7, 999, 1000, -2000, 3000, 4000, 1'b0));
      // capture only, position stays
      send_item(mk(MODE_SAMPLE, -8388608, -2097152, 5, 5, 3000, 4000, 1'b0));
      // full 25-bit travel delta
      send_item(mk(MODE_SAMPLE, 8388607, 2097151, 5, 5, 3000, 4000, 1'b1));
   endtask

   task automatic test_level_target();
      send_item(mk(MODE_SET, 0, 0, 100, 100, 500, 100, 1'b0));
      send_item(mk(MODE_SET, 0, 0, 100, 100, -500, 100, 1'b1));
      send_item(mk(MODE_SET, 0, 0, 100, 100, 100, 100, 1'b0));
   endtask

   task automatic test_reversal();
      send_item(mk(MODE_SET, 0, 0, 0, 0, 300, -400, 1'b0));
      send_item(mk(MODE_SET, 0, 0, 0, 0, -300, -400, 1'b0));
      send_item(mk(MODE_SET, 0, 0, 0, 0, 0, -400, 1'b0));
      send_item(mk(MODE_SET, 0, 0, 0, 0, 300, 400, 1'b1));
      send_item(mk(MODE_SET, 0, 0, 0, 0, -300, 400, 1'b1));
      send_item(mk(MODE_SET, 0, 0, 0, 0, 0, 400, 1'b1));
      send_item(mk(MODE_SET, 0, 0, 0, 0, 300, 400, 1'b0));
   endtask

   task automatic test_saturation();
      send_item(mk(MODE_SET, 0, 0, P_MAX - 10, P_MIN + 10, P_MIN, P_MAX, 1'b0));
      send_item(mk(MODE_SAMPLE, P_MIN, 5760, 0, 0, P_MIN, P_MAX, 1'b0));
      send_item(mk(MODE_SAMPLE, P_MAX, 5760, 0, 0, P_MIN, P_MAX, 1'b0));
      send_item(mk(MODE_SAMPLE, P_MIN, 11520, 0, 0, P_MAX, P_MIN, 1'b1));
      send_item(mk(MODE_SET, 0, 0, P_MIN, P_MIN, P_MAX, P_MAX, 1'b1));
      send_item(mk(MODE_SET, 0, 0, P_MAX, P_MAX, P_MIN, P_MIN, 1'b0));
   endtask

   // set, then a run of samples with plausible travel and heading steps, or now and then one random noise item
   task automatic test_random_walk(input int n_items);
      int sent;
      longint tr, hd, tx, ty;
      sent = 0;
      while (sent < n_items) begin
         tr = $signed($urandom);
         hd = $signed($urandom) >>> 10;
         if ($urandom_range(0, 9) == 0) begin
            send_item(noise_item());
            sent++;
         end else begin
            send_item(mk(MODE_SET, $urandom, $urandom,
                         $signed($urandom) >>> $urandom_range(8, 20),
                         $signed($urandom) >>> $urandom_range(8, 20),
                         $urandom, $urandom, $urandom_range(0, 1)));
            sent++;
            tx = $signed($urandom) >>> $urandom_range(8, 20);
            ty = $signed($urandom) >>> $urandom_range(8, 20);
            repeat ($urandom_range(1, 12)) begin
               tr += $signed($urandom) >>> $urandom_range(18, 30);
               hd += $signed($urandom) >>> $urandom_range(14, 30);
               if ($urandom_range(0, 7) == 0) begin
                  tx = $urandom; ty = $urandom;
               end
               send_item(mk(MODE_SAMPLE, tr, hd, $urandom, $urandom, tx, ty,
                            $urandom_range(0, 1)));
               sent++;
            end
         end
      end
   endtask

   initial begin
      int waited;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      odo_x = 0; odo_y = 0; ref_travel = 0; ref_heading = 0; cur_heading = 0;
      primed = 1'b0;
      @(posedge clock);
      test_first_capture();
      test_set_position();
      test_level_target();
      test_reversal();
      test_saturation();
      test_random_walk(1400);
      idle_on = 1'b0;
      test_random_walk(300);
      req_tvalid <= 1'b0;
      waited = 0;
      while (pending_rsp.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (120) @(posedge clock);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #12ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

### filelist.f
hdl/owtb_pkg.sv
hdl/owtb_cordic.sv
hdl/owtb_dp.sv
hdl/owtb_ctrl.sv
hdl/odometry_with_target_bearing.sv
sim/odometry_with_target_bearing_tb.sv
